[hw/rtl/hgd_pkg.sv]
// Shared types and constants for the heat grid diffusion block.
package hgd_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [16:0] DT_MAX    = 17'd65536;
    localparam logic [16:0] DECAY_Q16 = 17'd64881;

    // Shared unit operation codes
    localparam logic [1:0] ALU_RATE  = 2'd0;
    localparam logic [1:0] ALU_HALF  = 2'd1;
    localparam logic [1:0] ALU_RSUM  = 2'd2;
    localparam logic [1:0] ALU_DECAY = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         cell_x;
        logic [6:0]         cell_y;
        logic signed [31:0] write_value;
        logic [16:0]        time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic signed [31:0] gradient_x;
        logic signed [31:0] gradient_y;
        logic [31:0]        elapsed_time;
        logic               done_res;
    } t_out_item;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [33:0] a;
        logic signed [33:0] b;
        logic signed [33:0] c;
        logic [16:0]        k;
    } t_alu_req;

endpackage

[hw/rtl/hgd_alu.sv]
// Shared arithmetic unit: multiply-add, rounded shift and saturation, combinational.
module hgd_alu
    import hgd_pkg::*;
(
    input  t_alu_req           i_req,
    output logic signed [31:0] o_res
);
    logic signed [67:0] w_full;
    logic signed [67:0] w_rnd;
    logic signed [67:0] w_sh;

    // Form the unscaled value, then round and shift per operation
    always_comb begin
        w_full = '0;
        w_rnd  = '0;
        w_sh   = '0;
        case (i_req.op)
            ALU_RATE: begin
                w_full = 68'(i_req.b) * $signed({1'b0, i_req.k});
                w_rnd  = w_full + 68'sd32768;
                w_sh   = (w_rnd >>> 16) + 68'(i_req.a);
            end
            ALU_HALF: begin
                w_full = 68'(i_req.a) + 68'(i_req.c) - (68'(i_req.b) <<< 1);
                w_rnd  = w_full + 68'sd1;
                w_sh   = w_rnd >>> 1;
            end
            ALU_RSUM: begin
                w_full = (68'(i_req.a) + 68'(i_req.b)) * 68'sd7;
                w_rnd  = w_full + 68'sd1;
                w_sh   = w_rnd >>> 1;
            end
            default: begin
                w_full = 68'(i_req.a) * $signed({1'b0, i_req.k});
                w_rnd  = w_full + 68'sd32768;
                w_sh   = w_rnd >>> 16;
            end
        endcase
        // Saturate to the signed 32-bit range
        if (w_sh > 68'sd2147483647) begin
            o_res = 32'sh7fffffff;
        end else if (w_sh < -68'sd2147483648) begin
            o_res = 32'sh80000000;
        end else begin
            o_res = w_sh[31:0];
        end
    end
endmodule

[hw/rtl/heat_grid_diffusion_step.sv]
// Top level of the heat grid diffusion block: grids, sequencer and handshakes.
//
//  channel | signals                         | moves
//  in      | i_in_valid/o_in_ready, i_in     | one operation item
//  out     | o_out_valid/i_out_ready, o_out  | one result item per operation
//  cfg     | i_cfg_valid/o_cfg_ready, i_cfg  | diffusion_enable write
//
// Write, unknown and disabled-step items go from accept straight to result; a read passes S_RD.
// An enabled step walks all cells in pass one (S_P1A, S_P1B), in pass two (S_P2A for a border
// cell, S_P2A to S_P2F for an interior cell, set by the single port of the temperature memory)
// and in pass three (S_P3A to S_P3C), then gives its result.
// After reset a clearing pass over all CELLS cells zeroes the grids; no item is accepted meanwhile.
// Input is ready only in idle, so a result waiting on the receiver stalls the input.
module heat_grid_diffusion_step
    import hgd_pkg::*;
#(
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_HEIGHT = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg
);
    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [XW-1:0] LAST_X    = XW'(GRID_WIDTH - 1);
    localparam logic [YW-1:0] LAST_Y    = YW'(GRID_HEIGHT - 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_OUT  = 4'd3;
    localparam logic [3:0] S_P1A  = 4'd4;
    localparam logic [3:0] S_P1B  = 4'd5;
    localparam logic [3:0] S_P2A  = 4'd6;
    localparam logic [3:0] S_P2B  = 4'd7;
    localparam logic [3:0] S_P2C  = 4'd8;
    localparam logic [3:0] S_P2D  = 4'd9;
    localparam logic [3:0] S_P2E  = 4'd10;
    localparam logic [3:0] S_P2F  = 4'd11;
    localparam logic [3:0] S_P3A  = 4'd12;
    localparam logic [3:0] S_P3B  = 4'd13;
    localparam logic [3:0] S_P3C  = 4'd14;

    logic signed [31:0] r_tmem [CELLS];
    logic signed [31:0] r_rmem [CELLS];
    logic [63:0]        r_gmem [CELLS];

    logic [3:0]         r_state;
    logic [AW-1:0]      r_cnt;
    logic [XW-1:0]      r_x;
    logic [YW-1:0]      r_y;
    logic               r_en;
    logic [31:0]        r_time;
    logic               r_inside;
    logic [16:0]        r_dt;
    t_out_item          r_out;
    logic signed [31:0] r_t_rd;
    logic signed [31:0] r_r;
    logic [63:0]        r_g;
    logic signed [31:0] r_t;
    logic signed [31:0] r_tl;
    logic signed [31:0] r_tu;
    logic signed [31:0] r_gx;

    // Memory port controls
    logic               w_twe, w_rwe, w_gwe;
    logic [AW-1:0]      w_taddr, w_addr;
    logic signed [31:0] w_twd, w_rwd;
    logic [63:0]        w_gwd;

    t_alu_req           w_req;
    logic signed [31:0] w_alu;

    logic          w_border;
    logic          w_inside;
    logic [AW-1:0] w_cell;
    logic          w_last;
    logic [AW-1:0] n_cnt;
    logic [XW-1:0] n_x;
    logic [YW-1:0] n_y;

    hgd_alu u_alu (.i_req(w_req), .o_res(w_alu));

    // Walk the cells in index order with row and column kept alongside
    assign w_last   = (r_cnt == LAST_CELL);
    assign n_cnt    = w_last ? '0 : r_cnt + AW'(1);
    assign n_x      = (r_x == LAST_X) ? '0 : r_x + XW'(1);
    assign n_y      = w_last ? '0 : ((r_x == LAST_X) ? r_y + YW'(1) : r_y);
    assign w_border = (r_x == '0) || (r_x == LAST_X) || (r_y == '0) || (r_y == LAST_Y);
    assign w_inside = (32'(i_in.cell_x) < GRID_WIDTH) && (32'(i_in.cell_y) < GRID_HEIGHT);
    assign w_cell   = AW'(32'(i_in.cell_x) + GRID_WIDTH * 32'(i_in.cell_y));

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_state == S_OUT);
    assign o_out       = r_out;

    // Address and data selection per sequencer state
    always_comb begin
        w_twe = 1'b0; w_rwe = 1'b0; w_gwe = 1'b0;
        w_addr = r_cnt; w_taddr = r_cnt;
        w_twd = '0; w_rwd = '0; w_gwd = '0;
        w_req = '0;
        unique case (r_state)
            S_CLR: begin
                w_twe = 1'b1; w_rwe = 1'b1; w_gwe = 1'b1;
            end
            S_IDLE: begin
                w_addr = w_cell; w_taddr = w_cell;
                w_twd  = i_in.write_value;
                w_twe  = i_in_valid && (i_in.operation == OP_WRITE) && w_inside;
            end
            S_P1B: begin
                w_req = '{op: ALU_RATE, a: 34'(r_t_rd), b: 34'(r_r), c: '0, k: r_dt};
                w_twe = 1'b1; w_rwe = w_border;
                w_twd = w_border ? 32'sd0 : w_alu;
            end
            S_P2A: w_taddr = w_border ? r_cnt : r_cnt - AW'(1);
            S_P2B: w_taddr = r_cnt;
            S_P2C: w_taddr = r_cnt + AW'(1);
            S_P2D: begin
                w_taddr = r_cnt - AW'(GRID_WIDTH);
                w_req   = '{op: ALU_HALF, a: 34'(r_tl), b: 34'(r_t), c: 34'(r_t_rd), k: '0};
            end
            S_P2E: w_taddr = r_cnt + AW'(GRID_WIDTH);
            S_P2F: begin
                w_req = '{op: ALU_HALF, a: 34'(r_tu), b: 34'(r_t), c: 34'(r_t_rd), k: '0};
                w_gwe = 1'b1; w_gwd = {r_gx, w_alu};
            end
            S_P3B: begin
                w_req = '{op: ALU_RSUM, a: 34'($signed(r_g[63:32])),
                          b: 34'($signed(r_g[31:0])), c: '0, k: '0};
                w_rwe = 1'b1; w_rwd = w_alu;
            end
            S_P3C: begin
                w_req = '{op: ALU_DECAY, a: 34'(r_t_rd), b: '0, c: '0, k: DECAY_Q16};
                w_twe = 1'b1; w_twd = w_alu;
            end
            default: ;
        endcase
    end

    // Grid memories, one port each, registered read
    always_ff @(posedge i_clk) begin
        if (w_twe) r_tmem[w_taddr] <= w_twd;
        r_t_rd <= r_tmem[w_taddr];
        if (w_rwe) r_rmem[w_addr] <= w_rwd;
        r_r <= r_rmem[w_addr];
        if (w_gwe) r_gmem[w_addr] <= w_gwd;
        r_g <= r_gmem[w_addr];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_en    <= 1'b0;
            r_time  <= '0;
        end else begin
            if (i_cfg_valid) r_en <= i_cfg;
            unique case (r_state)
                S_CLR: begin
                    r_cnt <= n_cnt; r_x <= n_x; r_y <= n_y;
                    if (w_last) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_inside <= w_inside;
                        r_dt     <= (i_in.time_step > DT_MAX) ? DT_MAX : i_in.time_step;
                        if (i_in.operation == OP_READ) begin
                            r_state <= S_RD;
                        end else if (i_in.operation == OP_STEP && r_en) begin
                            r_state <= S_P1A;
                        end else begin
                            r_out   <= '{temperature: '0, gradient_x: '0, gradient_y: '0,
                                         elapsed_time: r_time,
                                         done_res: (i_in.operation != OP_NONE)};
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RD: begin
                    r_out   <= '{temperature: r_inside ? r_t_rd : 32'sd0,
                                 gradient_x: r_inside ? $signed(r_g[63:32]) : 32'sd0,
                                 gradient_y: r_inside ? $signed(r_g[31:0]) : 32'sd0,
                                 elapsed_time: r_time, done_res: 1'b1};
                    r_state <= S_OUT;
                end
                S_OUT: if (i_out_ready) r_state <= S_IDLE;
                S_P1A: r_state <= S_P1B;
                S_P1B: begin
                    r_cnt <= n_cnt; r_x <= n_x; r_y <= n_y;
                    r_state <= w_last ? S_P2A : S_P1A;
                end
                S_P2A: begin
                    if (w_border) begin
                        r_cnt <= n_cnt; r_x <= n_x; r_y <= n_y;
                        if (w_last) r_state <= S_P3A;
                    end else begin
                        r_state <= S_P2B;
                    end
                end
                S_P2B: begin r_tl <= r_t_rd; r_state <= S_P2C; end
                S_P2C: begin r_t <= r_t_rd; r_state <= S_P2D; end
                S_P2D: begin r_gx <= w_alu; r_state <= S_P2E; end
                S_P2E: begin r_tu <= r_t_rd; r_state <= S_P2F; end
                S_P2F: begin
                    r_cnt <= n_cnt; r_x <= n_x; r_y <= n_y;
                    r_state <= w_last ? S_P3A : S_P2A;
                end
                S_P3A: r_state <= S_P3B;
                S_P3B: r_state <= S_P3C;
                S_P3C: begin
                    r_cnt <= n_cnt; r_x <= n_x; r_y <= n_y;
                    if (w_last) begin
                        r_time  <= r_time + 32'(r_dt);
                        r_out   <= '{temperature: '0, gradient_x: '0, gradient_y: '0,
                                     elapsed_time: r_time + 32'(r_dt), done_res: 1'b1};
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_P3A;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result is held stable until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while result held");
endmodule

[tb/heat_grid_diffusion_step_tb.sv]
// Self-checking testbench for the heat grid diffusion block: write, read and step items.
module heat_grid_diffusion_step_tb
    import hgd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GW = 32;
    localparam int GH = 64;
    localparam int CELLS = GW * GH;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE_CYCLES = 64;

    // Grid predictor and queue of expected result items
    class grid_scoreboard;
        int temp_q[CELLS];
        int rate_q[CELLS];
        int gx_q[CELLS];
        int gy_q[CELLS];
        bit [31:0] elapsed;
        bit enable;
        int errors;
        t_out_item want_q[$];

        static function int sat32(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return int'(v);
        endfunction

        // round to nearest, ties toward +inf
        static function longint rshift(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function bit edge_cell(int x, int y);
            return x == 0 || x == GW - 1 || y == 0 || y == GH - 1;
        endfunction

        function void diffuse(longint dt);
            int x, y;
            longint c, sx, sy;
            for (int i = 0; i < CELLS; i++) begin
                x = i % GW;
                y = i / GW;
                if (edge_cell(x, y)) begin
                    temp_q[i] = 0;
                    rate_q[i] = 0;
                end else begin
                    temp_q[i] = sat32(longint'(temp_q[i]) + rshift(longint'(rate_q[i]) * dt, 16));
                end
            end
            for (int i = 0; i < CELLS; i++) begin
                x = i % GW;
                y = i / GW;
                if (!edge_cell(x, y)) begin
                    c = temp_q[i];
                    sx = longint'(temp_q[i + 1]) - 2 * c + longint'(temp_q[i - 1]);
                    sy = longint'(temp_q[i + GW]) - 2 * c + longint'(temp_q[i - GW]);
                    gx_q[i] = sat32(rshift(sx, 1));
                    gy_q[i] = sat32(rshift(sy, 1));
                end
            end
            for (int i = 0; i < CELLS; i++) begin
                rate_q[i] = sat32(rshift((longint'(gx_q[i]) + longint'(gy_q[i])) * 7, 1));
                temp_q[i] = sat32(rshift(longint'(temp_q[i]) * DECAY_Q16, 16));
            end
            elapsed = elapsed + 32'(dt);
        endfunction

        // Predict the result of one accepted item
        function void note_input(t_in_item it);
            t_out_item r;
            bit in_grid;
            int idx;
            longint dt;
            in_grid = it.cell_x < GW && it.cell_y < GH;
            idx = it.cell_x + GW * it.cell_y;
            dt = (it.time_step > DT_MAX) ? DT_MAX : it.time_step;
            r = '0;
            r.done_res = 1'b1;
            case (it.operation)
                OP_WRITE: if (in_grid) temp_q[idx] = it.write_value;
                OP_READ: if (in_grid) begin
                    r.temperature = temp_q[idx];
                    r.gradient_x = gx_q[idx];
                    r.gradient_y = gy_q[idx];
                end
                OP_STEP: if (enable) diffuse(dt);
                default: r.done_res = 1'b0;
            endcase
            r.elapsed_time = elapsed;
            want_q.push_back(r);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(t_out_item got);
            t_out_item w;
            if (want_q.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
                return;
            end
            w = want_q.pop_front();
            if (got.temperature !== w.temperature) begin
                $error("temperature expected %0d got %0d", w.temperature, got.temperature);
                errors++;
            end
            if (got.gradient_x !== w.gradient_x) begin
                $error("gradient_x expected %0d got %0d", w.gradient_x, got.gradient_x);
                errors++;
            end
            if (got.gradient_y !== w.gradient_y) begin
                $error("gradient_y expected %0d got %0d", w.gradient_y, got.gradient_y);
                errors++;
            end
            if (got.elapsed_time !== w.elapsed_time) begin
                $error("elapsed_time expected %0h got %0h", w.elapsed_time, got.elapsed_time);
                errors++;
            end
            if (got.done_res !== w.done_res) begin
                $error("done_res expected %0b got %0b", w.done_res, got.done_res);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic      i_cfg;

    grid_scoreboard board;
    int hold_off;
    int cycle_count;

    heat_grid_diffusion_step #(.GRID_WIDTH(GW), .GRID_HEIGHT(GH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg(i_cfg)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: check results, stall on its own pattern, honor long hold-offs
    initial begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) board.check_result(o_out);
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(5, 60);
            end
            left--;
            if (hold_off > 0) begin
                hold_off--;
                i_out_ready <= 1'b0;
            end else if (mode == 0) begin
                i_out_ready <= 1'b1;
            end else if (mode == 1) begin
                i_out_ready <= ($urandom_range(0, 3) != 0);
            end else begin
                i_out_ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Timeout watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("heat_grid_diffusion_step_tb: errors");
                $finish;
            end
        end
    end

    // Offer one item and hold it until accepted; valid stays high afterward
    task automatic send_item(t_in_item it);
        i_in <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_input(it);
    endtask

    task automatic pause_input(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Wait until every expected result has come, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.want_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(bit v);
        drain();
        i_cfg <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        board.enable = v;
    endtask

    function automatic t_in_item make_item(logic [1:0] op, int x, int y, int v, int dt);
        t_in_item it;
        it.operation = op;
        it.cell_x = 6'(x);
        it.cell_y = 7'(y);
        it.write_value = v;
        it.time_step = 17'(dt);
        return it;
    endfunction

    function automatic t_in_item random_item(int step_pct);
        t_in_item it;
        int pick;
        it.write_value = $urandom;
        it.time_step = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        it.cell_x = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, GW - 1));
        it.cell_y = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, GH - 1));
        pick = $urandom_range(0, 99);
        if (pick < step_pct) it.operation = OP_STEP;
        else if (pick < step_pct + 3) it.operation = OP_NONE;
        else if (pick < 55) it.operation = OP_WRITE;
        else it.operation = OP_READ;
        return it;
    endfunction

    // Random traffic in bursts with gaps
    task automatic random_phase(int count, int step_pct);
        int burst;
        while (count > 0) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && count > 0) begin
                send_item(random_item(step_pct));
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) != 0) pause_input($urandom_range(1, 6));
        end
    endtask

    initial begin
        t_in_item dir_q[$];
        board = new();
        hold_off = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, borders, out-of-grid cells, unknown op, oversized dt
        write_enable(1'b1);
        dir_q.push_back(make_item(OP_WRITE, 1, 1, 32'sh7fffffff, 0));
        dir_q.push_back(make_item(OP_WRITE, 2, 1, 32'sh80000000, 0));
        dir_q.push_back(make_item(OP_WRITE, 1, 2, 32'sh80000000, 0));
        dir_q.push_back(make_item(OP_WRITE, 0, 0, 32'sh00012345, 0));
        dir_q.push_back(make_item(OP_WRITE, 40, 5, 32'sh7fffffff, 0));
        dir_q.push_back(make_item(OP_WRITE, 5, 100, 32'sh7fffffff, 0));
        dir_q.push_back(make_item(OP_READ, 1, 1, 0, 0));
        dir_q.push_back(make_item(OP_READ, 63, 127, 32'shffffffff, 17'h1ffff));
        dir_q.push_back(make_item(OP_NONE, 3, 3, 32'sh7fffffff, 17'h1ffff));
        dir_q.push_back(make_item(OP_STEP, 0, 0, 0, 17'h1ffff));
        dir_q.push_back(make_item(OP_READ, 1, 1, 0, 0));
        dir_q.push_back(make_item(OP_READ, 2, 1, 0, 0));
        dir_q.push_back(make_item(OP_READ, 1, 2, 0, 0));
        dir_q.push_back(make_item(OP_READ, 0, 0, 0, 0));
        dir_q.push_back(make_item(OP_STEP, 0, 0, 0, 0));
        dir_q.push_back(make_item(OP_STEP, 0, 0, 0, 65536));
        dir_q.push_back(make_item(OP_READ, 2, 2, 0, 0));
        dir_q.push_back(make_item(OP_WRITE, GW - 1, GH - 1, -1, 0));
        dir_q.push_back(make_item(OP_READ, GW - 1, GH - 1, 0, 0));
        dir_q.push_back(make_item(OP_STEP, 0, 0, 0, 1));
        dir_q.push_back(make_item(OP_READ, 1, 1, 0, 0));
        foreach (dir_q[i]) send_item(dir_q[i]);

        // Disabled steps leave grids and time alone
        write_enable(1'b0);
        send_item(make_item(OP_WRITE, 4, 4, 32'sh00050000, 0));
        send_item(make_item(OP_STEP, 0, 0, 0, 65536));
        send_item(make_item(OP_READ, 4, 4, 0, 0));
        write_enable(1'b1);

        // Long receiver hold-off while the sender keeps offering items
        hold_off = 2000;
        random_phase(20, 5);

        // Sender pause until all results are in
        drain();
        random_phase(40, 12);
        write_enable(1'b0);
        random_phase(15, 20);
        write_enable(1'b1);
        random_phase(25, 12);

        drain();
        if (board.errors == 0 && board.want_q.size() == 0) begin
            $display("heat_grid_diffusion_step_tb: clean");
        end else begin
            $display("heat_grid_diffusion_step_tb: errors");
        end
        $finish;
    end
endmodule
